// ----- src/bf3_pkg.sv -----
// Shared constants, types and helpers for the 3x3 clipped-border box filter.
`timescale 1ns / 1ps
package bf3_pkg;

	localparam int MAX_SIDE   = 16;
	localparam int POS_W      = 6;   // covers the largest supported side (16)
	localparam int PIX_W      = 8;
	localparam int SIDE_CFG_W = 5;
	localparam int SUM_W      = 12;  // 9 * 255 fits
	localparam int RECIP_W    = 15;
	localparam int PROD_W     = SUM_W + RECIP_W;
	localparam int RECIP_SHIFT = 16;
	localparam int JOB_QUEUE_DEPTH = 2;

	typedef logic [1:0]            slot_t;
	typedef logic [POS_W-1:0]      pos_t;
	typedef logic [PIX_W-1:0]      pix_t;
	typedef logic [SIDE_CFG_W-1:0] side_cfg_t;
	typedef logic [SUM_W-1:0]      sum_t;
	typedef logic [RECIP_W-1:0]    recip_t;
	typedef logic [PROD_W-1:0]     prod_t;

	localparam side_cfg_t SIDE_RESET = side_cfg_t'(16);
	localparam side_cfg_t SIDE_MIN   = side_cfg_t'(2);
	localparam pos_t      POS_ONE    = pos_t'(1);

	// ceil(2^16 / n), exact floor for sums up to 9 * 255
	localparam recip_t RECIP_4 = recip_t'(16384);
	localparam recip_t RECIP_6 = recip_t'(10923);
	localparam recip_t RECIP_9 = recip_t'(7282);

	// One accepted pixel plus the results it triggers.
	typedef struct packed {
		pix_t   pixel;
		slot_t  slot;     // row slot of row
		pos_t   row;
		pos_t   col;
		pos_t   side;
		logic   has_mid;  // result at (row-1, col-1)
		logic   has_edge; // result at (row-1, side-1)
		logic   flush;    // whole last row follows
	} job_t;

	function automatic slot_t slot_inc(input slot_t s);
		slot_t r;
		case (s)
			2'd0: r = 2'd1;
			2'd1: r = 2'd2;
			default: r = 2'd0;
		endcase
		return r;
	endfunction

	function automatic slot_t slot_dec(input slot_t s);
		slot_t r;
		case (s)
			2'd1: r = 2'd0;
			2'd2: r = 2'd1;
			default: r = 2'd2;
		endcase
		return r;
	endfunction

endpackage

// ----- src/bf3_ifs.sv -----
// Stream interfaces for pixels, results and the frame side register.
`timescale 1ns / 1ps
interface bf3_pix_if;
	logic              valid;
	logic              ready;
	bf3_pkg::pix_t     pixel;
	modport source (output valid, pixel, input ready);
	modport sink   (input valid, pixel, output ready);
endinterface

interface bf3_res_if;
	logic          valid;
	logic          ready;
	bf3_pkg::pix_t smoothed;
	logic [3:0]    out_row;
	logic [3:0]    out_column;
	logic          last_of_run;
	modport source (output valid, smoothed, out_row, out_column, last_of_run, input ready);
	modport sink   (input valid, smoothed, out_row, out_column, last_of_run, output ready);
endinterface

interface bf3_cfg_if;
	logic                 valid;
	logic                 ready;
	bf3_pkg::side_cfg_t   frame_side;
	modport source (output valid, frame_side, input ready);
	modport sink   (input valid, frame_side, output ready);
endinterface

// ----- src/bf3_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module bf3_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- src/bf3_front.sv -----
// Front end: takes pixels, tracks raster position and classifies each into a job.
`timescale 1ns / 1ps
module bf3_front #(
	parameter int MAX_SIDE = bf3_pkg::MAX_SIDE
) (
	input  logic           clk,
	input  logic           arst_n,
	bf3_pix_if.sink        pix,
	bf3_cfg_if.sink        cfg,
	output bf3_pkg::job_t  job,
	output logic           job_push,
	input  logic           job_full
);

	bf3_pkg::side_cfg_t frame_side_q;
	bf3_pkg::pos_t      row_q;
	bf3_pkg::pos_t      col_q;
	bf3_pkg::slot_t     slot_q;
	bf3_pkg::pos_t      side;
	bf3_pkg::pos_t      side_m1;
	logic               col_last;
	logic               row_last;

	always_comb begin
		if (frame_side_q < bf3_pkg::SIDE_MIN) begin
			side = bf3_pkg::pos_t'(2);
		end else if (int'(frame_side_q) > MAX_SIDE) begin
			side = bf3_pkg::pos_t'(MAX_SIDE);
		end else begin
			side = bf3_pkg::pos_t'(frame_side_q);
		end
	end

	assign side_m1  = side - bf3_pkg::POS_ONE;
	assign col_last = (col_q == side_m1);
	assign row_last = (row_q == side_m1);

	assign pix.ready = !job_full;
	assign cfg.ready = 1'b1;
	assign job_push  = pix.valid && !job_full;

	always_comb begin
		job.pixel    = pix.pixel;
		job.slot     = slot_q;
		job.row      = row_q;
		job.col      = col_q;
		job.side     = side;
		job.has_mid  = (row_q != '0) && (col_q != '0);
		job.has_edge = (row_q != '0) && col_last;
		job.flush    = row_last && col_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_side_q <= bf3_pkg::SIDE_RESET;
			row_q        <= '0;
			col_q        <= '0;
			slot_q       <= '0;
		end else if (cfg.valid) begin
			// a new side restarts the frame
			frame_side_q <= cfg.frame_side;
			row_q        <= '0;
			col_q        <= '0;
			slot_q       <= '0;
		end else if (job_push) begin
			if (col_last) begin
				col_q <= '0;
				if (row_last) begin
					row_q  <= '0;
					slot_q <= '0;
				end else begin
					row_q  <= row_q + bf3_pkg::POS_ONE;
					slot_q <= bf3_pkg::slot_inc(slot_q);
				end
			end else begin
				col_q <= col_q + bf3_pkg::POS_ONE;
			end
		end
	end

endmodule

// ----- src/bf3_job_fifo.sv -----
// Short job queue between front end and back end.
`timescale 1ns / 1ps
module bf3_job_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  bf3_pkg::job_t din,
	output logic          full,
	input  logic          pop,
	output bf3_pkg::job_t dout,
	output logic          valid
);

	localparam int DEPTH = bf3_pkg::JOB_QUEUE_DEPTH;
	localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(DEPTH + 1);

	bf3_pkg::job_t  mem_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic           do_push;
	logic           do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign valid   = (count_q != '0);
	assign dout    = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- src/bf3_back.sv -----
// Back end: stores pixels in three row RAMs and walks neighbourhood columns per result.
`timescale 1ns / 1ps
module bf3_back #(
	parameter int MAX_SIDE = bf3_pkg::MAX_SIDE
) (
	input  logic          clk,
	input  logic          arst_n,
	input  bf3_pkg::job_t job,
	input  logic          job_valid,
	output logic          job_pop,
	bf3_res_if.source     res
);

	localparam int AW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_PICK = 4'b0010,
		S_READ = 4'b0100,
		S_DIV  = 4'b1000
	} state_t;

	state_t          state_q;
	bf3_pkg::job_t   job_q;
	logic            mid_pend_q;
	logic            edge_pend_q;
	logic            flush_pend_q;
	bf3_pkg::pos_t   fcol_q;
	bf3_pkg::pos_t   res_row_q;
	bf3_pkg::pos_t   res_col_q;
	logic            res_last_q;
	logic [2:0]      mask_q;
	logic            rows3_q;
	logic            cols3_q;
	bf3_pkg::pos_t   rd_col_q;
	bf3_pkg::pos_t   rd_end_q;
	logic            issue_q;
	logic            rd_v_s1;
	bf3_pkg::sum_t   acc_q;
	logic            res_valid_q;
	bf3_pkg::pix_t   smoothed_q;
	bf3_pkg::pos_t   out_row_q;
	bf3_pkg::pos_t   out_col_q;
	logic            out_last_q;

	logic            ram_we    [3];
	bf3_pkg::pix_t   ram_rdata [3];

	logic            sel_mid;
	logic            sel_edge;
	logic            sel_flush;
	logic            pick_go;
	bf3_pkg::pos_t   pick_row;
	bf3_pkg::slot_t  pick_slot;
	bf3_pkg::pos_t   pick_col;
	logic            pick_last;
	bf3_pkg::pos_t   side_m1;
	logic [2:0]      pick_mask;
	bf3_pkg::pos_t   pick_c0;
	bf3_pkg::pos_t   pick_c1;
	bf3_pkg::sum_t   col_sum;
	bf3_pkg::recip_t recip;
	bf3_pkg::prod_t  prod;
	logic            out_free;
	logic            job_has_result;

	assign job_pop = (state_q == S_IDLE) && job_valid;
	assign job_has_result = job.has_mid || job.has_edge || job.flush;

	for (genvar g = 0; g < 3; g++) begin : g_row
		assign ram_we[g] = job_pop && (job.slot == bf3_pkg::slot_t'(g));
		bf3_ram #(
			.WIDTH (bf3_pkg::PIX_W),
			.DEPTH (MAX_SIDE)
		) u_row_ram (
			.clk   (clk),
			.we    (ram_we[g]),
			.waddr (job.col[AW-1:0]),
			.wdata (job.pixel),
			.raddr (rd_col_q[AW-1:0]),
			.rdata (ram_rdata[g])
		);
	end

	assign side_m1   = job_q.side - bf3_pkg::POS_ONE;
	assign sel_mid   = mid_pend_q;
	assign sel_edge  = !mid_pend_q && edge_pend_q;
	assign sel_flush = !mid_pend_q && !edge_pend_q && flush_pend_q;
	assign pick_go   = mid_pend_q || edge_pend_q || flush_pend_q;

	always_comb begin
		pick_row  = job_q.row;
		pick_slot = job_q.slot;
		pick_col  = fcol_q;
		pick_last = (fcol_q == side_m1);
		if (sel_mid) begin
			pick_row  = job_q.row - bf3_pkg::POS_ONE;
			pick_slot = bf3_pkg::slot_dec(job_q.slot);
			pick_col  = job_q.col - bf3_pkg::POS_ONE;
			pick_last = !edge_pend_q && !flush_pend_q;
		end else if (sel_edge) begin
			pick_row  = job_q.row - bf3_pkg::POS_ONE;
			pick_slot = bf3_pkg::slot_dec(job_q.slot);
			pick_col  = side_m1;
			pick_last = !flush_pend_q;
		end
	end

	// rows of the clipped neighbourhood, by row slot
	always_comb begin
		pick_mask = '0;
		pick_mask[pick_slot] = 1'b1;
		if (pick_row != '0) begin
			pick_mask[bf3_pkg::slot_dec(pick_slot)] = 1'b1;
		end
		if (pick_row != side_m1) begin
			pick_mask[bf3_pkg::slot_inc(pick_slot)] = 1'b1;
		end
	end

	assign pick_c0 = (pick_col == '0) ? '0 : pick_col - bf3_pkg::POS_ONE;
	assign pick_c1 = (pick_col == side_m1) ? pick_col : pick_col + bf3_pkg::POS_ONE;

	assign col_sum = (mask_q[0] ? bf3_pkg::sum_t'(ram_rdata[0]) : '0)
		+ (mask_q[1] ? bf3_pkg::sum_t'(ram_rdata[1]) : '0)
		+ (mask_q[2] ? bf3_pkg::sum_t'(ram_rdata[2]) : '0);

	// divide by 4, 6 or 9 through a reciprocal multiply
	always_comb begin
		if (rows3_q && cols3_q) begin
			recip = bf3_pkg::RECIP_9;
		end else if (rows3_q || cols3_q) begin
			recip = bf3_pkg::RECIP_6;
		end else begin
			recip = bf3_pkg::RECIP_4;
		end
	end

	assign prod     = bf3_pkg::prod_t'(acc_q) * bf3_pkg::prod_t'(recip);
	assign out_free = !res_valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			mid_pend_q   <= 1'b0;
			edge_pend_q  <= 1'b0;
			flush_pend_q <= 1'b0;
			issue_q      <= 1'b0;
			rd_v_s1      <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			rd_v_s1 <= (state_q == S_READ) && issue_q;
			if ((state_q == S_DIV) && out_free) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (job_valid) begin
						mid_pend_q   <= job.has_mid;
						edge_pend_q  <= job.has_edge;
						flush_pend_q <= job.flush;
						if (job_has_result) begin
							state_q <= S_PICK;
						end
					end
				end
				S_PICK: begin
					if (pick_go) begin
						if (sel_mid) begin
							mid_pend_q <= 1'b0;
						end
						if (sel_edge) begin
							edge_pend_q <= 1'b0;
						end
						if (sel_flush && pick_last) begin
							flush_pend_q <= 1'b0;
						end
						issue_q <= 1'b1;
						state_q <= S_READ;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_READ: begin
					if (issue_q && (rd_col_q == rd_end_q)) begin
						issue_q <= 1'b0;
					end
					if (!issue_q && !rd_v_s1) begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (out_free) begin
						state_q <= res_last_q ? S_IDLE : S_PICK;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (job_pop) begin
			job_q  <= job;
			fcol_q <= '0;
		end
		if ((state_q == S_PICK) && pick_go) begin
			res_row_q  <= pick_row;
			res_col_q  <= pick_col;
			res_last_q <= pick_last;
			mask_q     <= pick_mask;
			rows3_q    <= (pick_row != '0) && (pick_row != side_m1);
			cols3_q    <= (pick_col != '0) && (pick_col != side_m1);
			rd_col_q   <= pick_c0;
			rd_end_q   <= pick_c1;
			acc_q      <= '0;
			if (sel_flush) begin
				fcol_q <= fcol_q + bf3_pkg::POS_ONE;
			end
		end
		if ((state_q == S_READ) && issue_q) begin
			rd_col_q <= rd_col_q + bf3_pkg::POS_ONE;
		end
		if (rd_v_s1) begin
			acc_q <= acc_q + col_sum;
		end
		// output payload stays put while a transfer waits on res.ready
		if ((state_q == S_DIV) && out_free) begin
			smoothed_q <= prod[bf3_pkg::RECIP_SHIFT +: bf3_pkg::PIX_W];
			out_row_q  <= res_row_q;
			out_col_q  <= res_col_q;
			out_last_q <= res_last_q;
		end
	end

	assign res.valid       = res_valid_q;
	assign res.smoothed    = smoothed_q;
	assign res.out_row     = out_row_q[3:0];
	assign res.out_column  = out_col_q[3:0];
	assign res.last_of_run = out_last_q;

endmodule

// ----- src/box_filter_3x3_clipped_border_core.sv -----
// Top level of the 3x3 clipped-border box filter.
`timescale 1ns / 1ps
// Pixels of a square frame (side set by frame_side, clamped to 2..MAX_SIDE) enter in raster
// order; each is smoothed to the truncated mean of its clipped 3x3 neighbourhood and comes out
// one row late, and the frame's last pixel also releases the whole last row. Writing frame_side
// restarts the frame. A front end takes a pixel every cycle while the two-entry job queue has
// room; the back end stores the pixel in one of three row RAMs and then produces each result
// by reading the two or three columns of the neighbourhood one by one through the RAMs' single
// read port and dividing the sum by 4, 6 or 9; it takes the next pixel from the queue only after
// it has produced every result of the last one, and a stalled result sink holds it. The row RAMs
// need no clearing after reset.
module box_filter_3x3_clipped_border_core #(
	parameter int MAX_SIDE = bf3_pkg::MAX_SIDE
) (
	input  logic      clk,
	input  logic      arst_n,
	bf3_pix_if.sink   pix,
	bf3_cfg_if.sink   cfg,
	bf3_res_if.source res
);

	bf3_pkg::job_t push_job;
	bf3_pkg::job_t head_job;
	logic          job_push;
	logic          job_full;
	logic          job_valid;
	logic          job_pop;

	bf3_front #(
		.MAX_SIDE (MAX_SIDE)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.pix      (pix),
		.cfg      (cfg),
		.job      (push_job),
		.job_push (job_push),
		.job_full (job_full)
	);

	bf3_job_fifo u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.din    (push_job),
		.full   (job_full),
		.pop    (job_pop),
		.dout   (head_job),
		.valid  (job_valid)
	);

	bf3_back #(
		.MAX_SIDE (MAX_SIDE)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (head_job),
		.job_valid (job_valid),
		.job_pop   (job_pop),
		.res       (res)
	);

endmodule

// ----- bench/tb_box_filter_3x3_clipped_border_core.sv -----
// Self-checking bench for the 3x3 clipped-border box filter: directed table plus random frames.
`timescale 1ns / 1ps
module tb_box_filter_3x3_clipped_border_core;

	localparam int SETTLE      = 30;         // idle cycles before a side write and at the end
	localparam int PIXEL_GOAL  = 470;
	localparam int N_DIRECTED  = 27;
	localparam int N_FIRST     = 6;
	localparam int STORE_DEPTH = 3 * bf3_pkg::MAX_SIDE;

	typedef enum logic {K_PIXEL, K_SIDE} step_kind_t;

	// typed = 1: every result caused by this pixel must carry mean
	typedef struct packed {
		step_kind_t    kind;
		logic [7:0]    value;
		logic          typed;
		bf3_pkg::pix_t mean;
	} dir_row_t;

	typedef struct packed {
		bf3_pkg::pix_t smoothed;
		logic [3:0]    row;
		logic [3:0]    col;
		logic          last;
	} mean_res_t;

	localparam dir_row_t DIRECTED [N_DIRECTED] = '{
		'{K_SIDE,  8'd2,   1'b0, 8'd0},
		'{K_PIXEL, 8'hFF,  1'b1, 8'hFF},
		'{K_PIXEL, 8'hFF,  1'b1, 8'hFF},
		'{K_PIXEL, 8'hFF,  1'b1, 8'hFF},
		'{K_PIXEL, 8'hFF,  1'b1, 8'hFF},
		'{K_PIXEL, 8'h00,  1'b1, 8'h00},
		'{K_PIXEL, 8'h00,  1'b1, 8'h00},
		'{K_PIXEL, 8'h00,  1'b1, 8'h00},
		'{K_PIXEL, 8'h00,  1'b1, 8'h00},
		'{K_SIDE,  8'd3,   1'b0, 8'd0},
		'{K_PIXEL, 8'h00,  1'b0, 8'h00},
		'{K_PIXEL, 8'hFF,  1'b0, 8'h00},
		'{K_PIXEL, 8'h00,  1'b0, 8'h00},
		'{K_PIXEL, 8'hFF,  1'b0, 8'h00},
		'{K_PIXEL, 8'h00,  1'b0, 8'h00},
		'{K_PIXEL, 8'hFF,  1'b0, 8'h00},
		'{K_PIXEL, 8'h00,  1'b0, 8'h00},
		'{K_PIXEL, 8'hFF,  1'b0, 8'h00},
		'{K_PIXEL, 8'h00,  1'b0, 8'h00},
		'{K_SIDE,  8'd1,   1'b0, 8'd0},  // below the minimum: acts as 2
		'{K_PIXEL, 8'h55,  1'b0, 8'h00},
		'{K_PIXEL, 8'hAA,  1'b0, 8'h00},
		'{K_PIXEL, 8'h0F,  1'b0, 8'h00},
		'{K_PIXEL, 8'hF0,  1'b0, 8'h00},
		'{K_SIDE,  8'd31,  1'b0, 8'd0},  // above the maximum: acts as 16
		'{K_PIXEL, 8'h80,  1'b0, 8'h00},
		'{K_PIXEL, 8'h7F,  1'b0, 8'h00}   // frame left unfinished on purpose
	};

	// side values of the first random phases; 31 gets one full largest frame
	localparam int FIRST_SIDES [N_FIRST] = '{2, 16, 0, 17, 1, 31};

	logic clk;
	logic arst_n;

	bf3_pix_if pix_ch ();
	bf3_cfg_if cfg_ch ();
	bf3_res_if res_ch ();

	box_filter_3x3_clipped_border_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.pix    (pix_ch),
		.cfg    (cfg_ch),
		.res    (res_ch)
	);

	// predictor state
	bf3_pkg::pix_t      frame_mem [STORE_DEPTH];
	int                 next_row;
	int                 next_col;
	bf3_pkg::side_cfg_t side_reg;
	mean_res_t          owed_means [$];

	int   errors;
	int   pixels_sent;
	int   results_seen;
	int   sides_written;
	int   frames_done;
	logic no_gaps;
	int   sink_hold;
	mean_res_t want;

	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int clamp_side(input bf3_pkg::side_cfg_t v);
		if (v < bf3_pkg::SIDE_MIN)
			return 2;
		if (v > bf3_pkg::side_cfg_t'(bf3_pkg::MAX_SIDE))
			return bf3_pkg::MAX_SIDE;
		return int'(v);
	endfunction

	function automatic mean_res_t box_mean(input int r, input int c, input int s);
		mean_res_t m;
		int r0, r1, c0, c1, sum, cnt;
		r0 = (r == 0) ? 0 : r - 1;
		r1 = (r + 1 < s) ? r + 1 : s - 1;
		c0 = (c == 0) ? 0 : c - 1;
		c1 = (c + 1 < s) ? c + 1 : s - 1;
		sum = 0;
		cnt = 0;
		for (int y = r0; y <= r1; y++)
			for (int x = c0; x <= c1; x++) begin
				sum += frame_mem[(y % 3) * bf3_pkg::MAX_SIDE + x];
				cnt++;
			end
		m.smoothed = bf3_pkg::pix_t'(sum / cnt);
		m.row      = r[3:0];
		m.col      = c[3:0];
		m.last     = 1'b0;
		return m;
	endfunction

	// stores one pixel and queues the smoothed results it releases
	task automatic filter_pixel(input bf3_pkg::pix_t p, input logic typed,
		input bf3_pkg::pix_t typed_mean);
		mean_res_t batch [$];
		int s, r, c;
		s = clamp_side(side_reg);
		r = next_row;
		c = next_col;
		if (r >= s || c >= s) begin
			r = 0;
			c = 0;
		end
		frame_mem[(r % 3) * bf3_pkg::MAX_SIDE + c] = p;
		if (r >= 1) begin
			if (c >= 1)
				batch.push_back(box_mean(r - 1, c - 1, s));
			if (c == s - 1)
				batch.push_back(box_mean(r - 1, s - 1, s));
		end
		if (r == s - 1 && c == s - 1) begin
			for (int x = 0; x < s; x++)
				batch.push_back(box_mean(s - 1, x, s));
			frames_done++;
		end
		if (batch.size() > 0)
			batch[batch.size() - 1].last = 1'b1;
		foreach (batch[i]) begin
			if (typed)
				batch[i].smoothed = typed_mean;
			owed_means.push_back(batch[i]);
		end
		c++;
		if (c >= s) begin
			c = 0;
			r++;
			if (r >= s)
				r = 0;
		end
		next_row = r;
		next_col = c;
	endtask

	task automatic send_pixel(input bf3_pkg::pix_t p, input logic typed,
		input bf3_pkg::pix_t typed_mean);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			pix_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix_ch.valid <= 1'b1;
		pix_ch.pixel <= p;
		do @(posedge clk); while (!pix_ch.ready);
		filter_pixel(p, typed, typed_mean);
		pixels_sent++;
	endtask

	// stop sending, let every owed result arrive, then let the back end settle
	task automatic drain();
		pix_ch.valid <= 1'b0;
		while (owed_means.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_side(input bf3_pkg::side_cfg_t v);
		drain();
		cfg_ch.valid      <= 1'b1;
		cfg_ch.frame_side <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		side_reg = v;
		next_row = 0;
		next_col = 0;
		sides_written++;
	endtask

	// result sink: random stall after every transfer unless no_gaps is set
	always @(posedge clk) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			sink_hold = 0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				results_seen++;
				if (owed_means.size() == 0) begin
					$error("unexpected result: row %0d col %0d smoothed %0d",
						res_ch.out_row, res_ch.out_column, res_ch.smoothed);
					errors++;
				end else begin
					want = owed_means.pop_front();
					if (res_ch.smoothed !== want.smoothed) begin
						$error("smoothed: expected %0d, got %0d", want.smoothed,
							res_ch.smoothed);
						errors++;
					end
					if (res_ch.out_row !== want.row) begin
						$error("out_row: expected %0d, got %0d", want.row, res_ch.out_row);
						errors++;
					end
					if (res_ch.out_column !== want.col) begin
						$error("out_column: expected %0d, got %0d", want.col,
							res_ch.out_column);
						errors++;
					end
					if (res_ch.last_of_run !== want.last) begin
						$error("last_of_run: expected %0d, got %0d", want.last,
							res_ch.last_of_run);
						errors++;
					end
				end
				sink_hold = no_gaps ? 0 : $urandom_range(0, 7);
			end
			if (sink_hold == 0) begin
				res_ch.ready <= 1'b1;
			end else begin
				res_ch.ready <= 1'b0;
				sink_hold--;
			end
		end
	end

	initial begin
		int k, sval, s, n;
		bf3_pkg::pix_t p;
		logic extremes;
		errors        = 0;
		pixels_sent   = 0;
		results_seen  = 0;
		sides_written = 0;
		frames_done   = 0;
		no_gaps       = 1'b0;
		side_reg      = bf3_pkg::SIDE_RESET;
		next_row      = 0;
		next_col      = 0;
		foreach (frame_mem[i])
			frame_mem[i] = '0;
		arst_n            <= 1'b0;
		pix_ch.valid      <= 1'b0;
		pix_ch.pixel      <= '0;
		cfg_ch.valid      <= 1'b0;
		cfg_ch.frame_side <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIRECTED; i++) begin
			if (DIRECTED[i].kind == K_SIDE)
				write_side(bf3_pkg::side_cfg_t'(DIRECTED[i].value));
			else
				send_pixel(DIRECTED[i].value, DIRECTED[i].typed, DIRECTED[i].mean);
		end

		// random phases: each writes a side (restarting any open frame); the first 31 and sides up to 8
		// get whole frames, the latter sometimes followed by an unfinished one, other sides s to 3*s pixels
		k = 0;
		while (pixels_sent < PIXEL_GOAL) begin
			sval = (k < N_FIRST) ? FIRST_SIDES[k] : $urandom_range(0, 31);
			write_side(bf3_pkg::side_cfg_t'(sval));
			s = clamp_side(bf3_pkg::side_cfg_t'(sval));
			if (k < N_FIRST && sval == 31)
				n = s * s;
			else if (s <= 8)
				n = s * s * $urandom_range(1, 3)
					+ (($urandom_range(0, 2) == 0) ? $urandom_range(1, s * s - 1) : 0);
			else
				n = $urandom_range(s, 3 * s);
			if (n > PIXEL_GOAL - pixels_sent)
				n = PIXEL_GOAL - pixels_sent;
			no_gaps  = ($urandom_range(0, 3) == 0);
			extremes = ($urandom_range(0, 7) == 0);
			repeat (n) begin
				if (extremes)
					p = $urandom_range(0, 1) ? 8'hFF : 8'h00;
				else
					p = bf3_pkg::pix_t'($urandom_range(0, 255));
				send_pixel(p, 1'b0, '0);
				if ($urandom_range(0, 99) == 0)
					drain();
			end
			k++;
		end

		drain();
		$display("Sent %0d pixels under %0d frame side writes, %0d frames completed.",
			pixels_sent, sides_written, frames_done);
		$display("Checked %0d smoothed results, %0d mismatches.", results_seen, errors);
		if (errors == 0)
			$display("** box_filter_3x3_clipped_border_core: PASSED **");
		else
			$display("** box_filter_3x3_clipped_border_core: FAILED **");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Timeout: %0d results still owed.", owed_means.size());
		$display("** box_filter_3x3_clipped_border_core: FAILED **");
		$finish;
	end

endmodule

// ----- box_filter_3x3_clipped_border_core.f -----
src/bf3_pkg.sv
src/bf3_ifs.sv
src/bf3_ram.sv
src/bf3_front.sv
src/bf3_job_fifo.sv
src/bf3_back.sv
src/box_filter_3x3_clipped_border_core.sv
bench/tb_box_filter_3x3_clipped_border_core.sv
